>>> src/ascp_pkg.sv
`timescale 1ns / 1ps
// Package for the Ascon-p permutation block: item types, round constants,
// the queue geometry, the engine state type and the round function.
// Depends on nothing; every other file uses it.
package ascp_pkg;

  typedef logic [63:0] word_t;
  typedef logic [7:0]  rc_t;

  localparam rc_t RcLast  = 8'h4b;
  localparam rc_t RcStep  = 8'd15;
  // A round taken at a constant below this value is the last one.
  localparam rc_t RcFinal = RcLast + RcStep;

  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef struct packed {
    word_t x0;
    word_t x1;
    word_t x2;
    word_t x3;
    word_t x4;
  } state_t;

  typedef struct packed {
    word_t word_zero;
    word_t word_one;
    word_t word_two;
    word_t word_three;
    word_t word_four;
    rc_t   first_constant;
  } in_item_t;

  typedef struct packed {
    word_t out_zero;
    word_t out_one;
    word_t out_two;
    word_t out_three;
    word_t out_four;
  } out_item_t;

  // Work handed from the front to the round engine.
  typedef struct packed {
    state_t state;
    rc_t    rc;
    logic   skip;
  } job_t;

  typedef enum logic [1:0] {
    EngIdle,
    EngRun,
    EngHold
  } eng_state_e;

  function automatic word_t rotr(input word_t v, input int unsigned amt);
    rotr = (v >> amt) | (v << (64 - amt));
  endfunction

  function automatic state_t ascp_round(input state_t s, input rc_t rc);
    word_t a0, a1, a2, a3, a4;
    word_t n0, n1, n2, n3, n4;
    state_t r;
    a0 = s.x0;
    a1 = s.x1;
    a2 = s.x2 ^ {56'd0, rc};
    a3 = s.x3;
    a4 = s.x4;
    // Bitsliced S-box.
    a0 = a0 ^ a4;
    a4 = a4 ^ a3;
    a2 = a2 ^ a1;
    n0 = ~a0 & a1;
    n1 = ~a1 & a2;
    n2 = ~a2 & a3;
    n3 = ~a3 & a4;
    n4 = ~a4 & a0;
    a0 = a0 ^ n1;
    a1 = a1 ^ n2;
    a2 = a2 ^ n3;
    a3 = a3 ^ n4;
    a4 = a4 ^ n0;
    a1 = a1 ^ a0;
    a0 = a0 ^ a4;
    a3 = a3 ^ a2;
    a2 = ~a2;
    // Linear diffusion layer.
    r.x0 = a0 ^ rotr(a0, 19) ^ rotr(a0, 28);
    r.x1 = a1 ^ rotr(a1, 61) ^ rotr(a1, 39);
    r.x2 = a2 ^ rotr(a2, 1)  ^ rotr(a2, 6);
    r.x3 = a3 ^ rotr(a3, 10) ^ rotr(a3, 17);
    r.x4 = a4 ^ rotr(a4, 7)  ^ rotr(a4, 41);
    return r;
  endfunction

endpackage

>>> src/ascp_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input and result items.
// Depends on ascp_pkg for the payload types.
interface ascp_in_if;
  logic              valid;
  logic              ready;
  ascp_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ascp_out_if;
  logic               valid;
  logic               ready;
  ascp_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/ascp_front.sv
`timescale 1ns / 1ps
// Front stage: registers an input item, decides whether it needs any
// rounds and pushes it into the job queue. Depends on ascp_pkg, ascp_if.
module ascp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  ascp_in_if.sink         src_i,
  input  logic            full_i,
  output logic            push_o,
  output ascp_pkg::job_t  job_o
);
  import ascp_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     take;

  assign src_i.ready = !valid_q || !full_i;
  assign take        = src_i.valid && src_i.ready;
  assign push_o      = valid_q && !full_i;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= src_i.data;
    end
  end

  assign job_o.state.x0 = item_q.word_zero;
  assign job_o.state.x1 = item_q.word_one;
  assign job_o.state.x2 = item_q.word_two;
  assign job_o.state.x3 = item_q.word_three;
  assign job_o.state.x4 = item_q.word_four;
  assign job_o.rc       = item_q.first_constant;
  // Constants below the last round constant run no round at all.
  assign job_o.skip     = item_q.first_constant < RcLast;

endmodule

>>> src/ascp_queue.sv
`timescale 1ns / 1ps
// Short job queue between the front stage and the round engine.
// Depends on ascp_pkg for the job type and the queue depth.
module ascp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ascp_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output ascp_pkg::job_t job_o
);
  import ascp_pkg::*;

  job_t             entry_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;

  assign full_o  = count_q == QCntW'(QueueDepth);
  assign empty_o = count_q == '0;
  assign job_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

>>> src/ascp_engine.sv
`timescale 1ns / 1ps
// Round engine: takes jobs from the queue, runs one permutation round per
// cycle and drives the result register. Depends on ascp_pkg, ascp_if.
module ascp_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  ascp_pkg::job_t job_i,
  output logic           pop_o,
  ascp_out_if.source     dst_o
);
  import ascp_pkg::*;

  eng_state_e state_q, state_d;
  state_t     work_q;
  rc_t        rc_q;
  state_t     round_out;
  state_t     res_q;
  logic       res_valid_q, res_valid_d;
  logic       res_free;
  logic       final_pass;
  logic       step;
  logic       load_res;
  logic       res_from_round;

  assign round_out  = ascp_round(work_q, rc_q);
  assign res_free   = !res_valid_q || dst_o.ready;
  assign final_pass = rc_q < RcFinal;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      EngIdle: begin
        if (!empty_i) begin
          state_d = job_i.skip ? EngHold : EngRun;
        end
      end
      EngRun: begin
        if (final_pass) begin
          state_d = res_free ? EngIdle : EngHold;
        end
      end
      EngHold: begin
        if (res_free) begin
          state_d = EngIdle;
        end
      end
      default: state_d = EngIdle;
    endcase
  end

  always_comb begin
    pop_o          = 1'b0;
    step           = 1'b0;
    load_res       = 1'b0;
    res_from_round = 1'b0;
    unique case (state_q)
      EngIdle: begin
        pop_o = !empty_i;
      end
      EngRun: begin
        step           = 1'b1;
        load_res       = final_pass && res_free;
        res_from_round = 1'b1;
      end
      EngHold: begin
        load_res = res_free;
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (load_res) begin
      res_valid_d = 1'b1;
    end else if (dst_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= EngIdle;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  // A blocked last round parks its output in the work register; the
  // constant is no longer needed then.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      work_q <= job_i.state;
      rc_q   <= job_i.rc;
    end else if (step) begin
      work_q <= round_out;
      rc_q   <= rc_q - RcStep;
    end
    if (load_res) begin
      res_q <= res_from_round ? round_out : work_q;
    end
  end

  assign dst_o.valid          = res_valid_q;
  assign dst_o.data.out_zero  = res_q.x0;
  assign dst_o.data.out_one   = res_q.x1;
  assign dst_o.data.out_two   = res_q.x2;
  assign dst_o.data.out_three = res_q.x3;
  assign dst_o.data.out_four  = res_q.x4;

endmodule

>>> src/ascon_permutation.sv
`timescale 1ns / 1ps
// Ascon-p permutation on a 320-bit state, top level.
// Input channel src_i carries the five state words and the first round
// constant; result channel dst_o carries the five permuted words, one
// result item for each input item, in order.
// An input item is registered by the front stage, moves into a two-entry
// job queue, and is then taken by the round engine, which runs one round
// per cycle. A constant c at or above 0x4b gives N = floor((c - 0x4b)/15)+1
// rounds (12 for 0xf0, 6 for 0x96); below 0x4b the state passes unchanged.
// An accepted item passes through the front register, the job queue, the
// engine's work register and the result register. The round engine takes
// a new item from the queue only once it is through with the last one.
// The result register lets the engine finish its next item while a result
// waits; when dst_o stalls, the engine holds its result, then the queue and
// the front stage fill, and src_i.ready drops. Up to five items are inside.
// Reset clears all valid flags and the engine state; no item survives it.
// Depends on ascp_pkg, ascp_if, ascp_front, ascp_queue and ascp_engine.
module ascon_permutation (
  input  logic      clk_i,
  input  logic      rst_ni,
  ascp_in_if.sink   src_i,
  ascp_out_if.source dst_o
);
  import ascp_pkg::*;

  logic push;
  logic full;
  logic pop;
  logic empty;
  job_t front_job;
  job_t queue_job;

  ascp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .src_i  (src_i),
    .full_i (full),
    .push_o (push),
    .job_o  (front_job)
  );

  ascp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (queue_job)
  );

  ascp_engine u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .job_i   (queue_job),
    .pop_o   (pop),
    .dst_o   (dst_o)
  );

endmodule

>>> src/ascp_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the Ascon-p permutation block and its bind.
// Depends on ascp_pkg, ascp_if and the ascon_permutation top level.
module ascp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input ascp_pkg::out_item_t out_data_i
);
  import ascp_pkg::*;

  // Front register, queue, engine and result register.
  localparam int Capacity = QueueDepth + 3;
  localparam int CntW     = $clog2(Capacity + 1);

  logic [CntW-1:0] inside_q, inside_d;
  logic            in_acc;
  logic            out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    inside_d = inside_q;
    if (in_acc && !out_acc) begin
      inside_d = inside_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      inside_d = inside_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= '0;
    end else begin
      inside_q <= inside_d;
    end
  end

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid while in reset");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> inside_q != '0)
    else $error("result item shown with no item inside");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inside_q == CntW'(Capacity) |-> !in_ready_i)
    else $error("input ready although the block is full");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result item changed or dropped");

endmodule

bind ascon_permutation ascp_checker u_ascp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (src_i.valid),
  .in_ready_i  (src_i.ready),
  .out_valid_i (dst_o.valid),
  .out_ready_i (dst_o.ready),
  .out_data_i  (dst_o.data)
);

>>> test/ascp_checker.sv
`timescale 1ns / 1ps
// Result checker for the Ascon-p permutation block: watches both channels,
// predicts each permuted state and compares it with the block's result item.
// Depends on ascp_pkg and the channel interfaces in ascp_if.
module ascp_scoreboard (
  input  logic clk_i,
  input  logic rst_ni,
  ascp_in_if   src_i,
  ascp_out_if  dst_i,
  output int   fail_count_o,
  output int   pending_o
);
  import ascp_pkg::*;

  out_item_t expected_states[$];
  int        fail_count = 0;

  assign fail_count_o = fail_count;

  function automatic word_t ror64(input word_t v, input int unsigned amt);
    logic [127:0] wide;
    wide = {v, v} >> amt;
    return wide[63:0];
  endfunction

  // One Ascon round: constant addition, bitsliced S-box, linear layer.
  function automatic out_item_t mix_round(input out_item_t s, input rc_t rc);
    word_t b0, b1, b2, b3, b4;
    word_t t0, t1, t2, t3, t4;
    out_item_t r;
    b0 = s.out_zero ^ s.out_four;
    b4 = s.out_four ^ s.out_three;
    b2 = s.out_two ^ {56'd0, rc} ^ s.out_one;
    b1 = s.out_one;
    b3 = s.out_three;
    t0 = ~b0 & b1;
    t1 = ~b1 & b2;
    t2 = ~b2 & b3;
    t3 = ~b3 & b4;
    t4 = ~b4 & b0;
    b0 = b0 ^ t1;
    b1 = b1 ^ t2;
    b2 = b2 ^ t3;
    b3 = b3 ^ t4;
    b4 = b4 ^ t0;
    b1 = b1 ^ b0;
    b0 = b0 ^ b4;
    b3 = b3 ^ b2;
    b2 = ~b2;
    r.out_zero  = b0 ^ ror64(b0, 19) ^ ror64(b0, 28);
    r.out_one   = b1 ^ ror64(b1, 61) ^ ror64(b1, 39);
    r.out_two   = b2 ^ ror64(b2, 1)  ^ ror64(b2, 6);
    r.out_three = b3 ^ ror64(b3, 10) ^ ror64(b3, 17);
    r.out_four  = b4 ^ ror64(b4, 7)  ^ ror64(b4, 41);
    return r;
  endfunction

  function automatic out_item_t permute_state(input in_item_t item);
    out_item_t s;
    int        c;
    s.out_zero  = item.word_zero;
    s.out_one   = item.word_one;
    s.out_two   = item.word_two;
    s.out_three = item.word_three;
    s.out_four  = item.word_four;
    c = item.first_constant;
    while (c >= RcLast) begin
      s = mix_round(s, rc_t'(c));
      c = c - RcStep;
    end
    return s;
  endfunction

  function automatic void check_word(input string name, input word_t exp_w,
                                     input word_t act_w);
    if (exp_w !== act_w) begin
      $error("%s mismatch: expected %h, got %h", name, exp_w, act_w);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : watch
    out_item_t exp_s;
    out_item_t got;
    if (rst_ni) begin
      if (dst_i.valid && dst_i.ready) begin
        got = dst_i.data;
        if (expected_states.size() == 0) begin
          $error("result item with no input pending: %h", got);
          fail_count++;
        end else begin
          exp_s = expected_states.pop_front();
          check_word("out_zero",  exp_s.out_zero,  got.out_zero);
          check_word("out_one",   exp_s.out_one,   got.out_one);
          check_word("out_two",   exp_s.out_two,   got.out_two);
          check_word("out_three", exp_s.out_three, got.out_three);
          check_word("out_four",  exp_s.out_four,  got.out_four);
        end
      end
      if (src_i.valid && src_i.ready)
        expected_states.push_back(permute_state(src_i.data));
    end
    pending_o <= expected_states.size();
  end

endmodule

>>> test/ascon_permutation_tb.sv
`timescale 1ns / 1ps
// Testbench top for ascon_permutation: clock, reset, item stimulus with
// random idling, random and long result back-pressure, and the verdict.
// Depends on ascp_pkg, ascp_if, the block itself and ascp_scoreboard.
module ascon_permutation_tb;
  import ascp_pkg::*;

  localparam int NumRandom  = 1230;
  localparam int TailItems  = 150;
  localparam int HoldAt     = 400;
  localparam int HoldCycles = 400;
  localparam int CycleLimit = 400000;

  logic clk_i;
  logic rst_ni;
  int   cycle_count = 0;
  int   items_sent  = 0;
  int   fail_count;
  int   pending;

  ascp_in_if  src_ch ();
  ascp_out_if dst_ch ();

  ascon_permutation uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .src_i  (src_ch),
    .dst_o  (dst_ch)
  );

  ascp_scoreboard scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .src_i        (src_ch),
    .dst_i        (dst_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("Simulation FAILED");
    $finish;
  end

  // Idling stops near the end of the run and in some quiet windows.
  function automatic bit quiet_now();
    return (items_sent >= NumRandom - TailItems) || ((items_sent / 100) % 4 == 2);
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic rc_t rand_constant();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      return 8'hf0;
    else if (pick < 60) return 8'h96;
    else if (pick < 75) return rc_t'($urandom_range(0, RcLast - 1));
    else if (pick < 82) return rc_t'($urandom_range(8'hf1, 8'hff));
    else                return rc_t'($urandom_range(0, 255));
  endfunction

  task automatic feed_item(input in_item_t item);
    if (!quiet_now() && $urandom_range(0, 3) == 0) begin
      src_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    src_ch.valid <= 1'b1;
    src_ch.data  <= item;
    do @(posedge clk_i); while (!src_ch.ready);
    items_sent++;
  endtask

  initial begin : result_drain
    dst_ch.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (items_sent >= HoldAt && items_sent < HoldAt + 50 && cycle_count % 2 == 0
          && !quiet_now()) begin
        // Long stall so the queue and front stage fill and the input stops.
        dst_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        dst_ch.ready <= 1'b1;
        wait (items_sent >= HoldAt + 50);
      end else if (!quiet_now() && $urandom_range(0, 7) == 0) begin
        dst_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        dst_ch.ready <= 1'b1;
      end else begin
        dst_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : item_feed
    in_item_t item;
    rc_t      dir_rc[18];
    word_t    w;
    dir_rc = '{8'h00, 8'h4a, 8'h4b, 8'h59, 8'h5a, 8'h69, 8'h96, 8'hb4, 8'hf0,
               8'hf0, 8'hf0, 8'hf1, 8'hff, 8'h96, 8'h4b, 8'h00, 8'h80, 8'h7f};
    src_ch.valid <= 1'b0;
    src_ch.data  <= '0;
    wait (rst_ni);
    @(posedge clk_i);
    // Directed: zero, all-ones, alternating and mixed states at round-count edges.
    for (int d = 0; d < 18; d++) begin
      case (d % 4)
        0:       w = '0;
        1:       w = '1;
        2:       w = 64'h5555_5555_5555_5555;
        default: w = 64'haaaa_aaaa_aaaa_aaaa;
      endcase
      item.word_zero      = w;
      item.word_one       = (d > 8) ? rand_word() : w;
      item.word_two       = w;
      item.word_three     = (d > 8) ? ~w : w;
      item.word_four      = w;
      item.first_constant = dir_rc[d];
      feed_item(item);
    end
    for (int n = 0; n < NumRandom; n++) begin
      item.word_zero      = rand_word();
      item.word_one       = rand_word();
      item.word_two       = rand_word();
      item.word_three     = rand_word();
      item.word_four      = rand_word();
      item.first_constant = rand_constant();
      feed_item(item);
    end
    src_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
